/* sv/smh_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smh_pkg
// shared types and constants of the sobel magnitude histogram block
// ----------------------------------------------------------------------------
package smh_pkg;

    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int NUM_LANES  = 3;
    localparam int TAPS       = 9;
    localparam int BIN_W      = 3;
    localparam int HIST_AW    = 9;
    localparam int HIST_DEPTH = 512;
    localparam int CNT_W      = 23;
    localparam int CFG_W      = 12;
    localparam int SQ_W       = 18;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam logic [1:0] MODE_PIXEL = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    typedef logic [TAPS-1:0][CH_W-1:0] lane_pix_t;
    typedef logic [NUM_LANES-1:0][CH_W-1:0] mag_set_t;

    typedef enum logic [1:0] {
        HOP_NONE  = 2'd0,
        HOP_CLEAR = 2'd1,
        HOP_READ  = 2'd2,
        HOP_INC   = 2'd3
    } hist_op_t;

    typedef struct packed {
        hist_op_t           op;
        logic [HIST_AW-1:0] addr;
    } hist_cmd_t;

    // bin triple from the three channel magnitudes
    function automatic logic [HIST_AW-1:0] bin_of(input mag_set_t mags);
        bin_of = {mags[0][CH_W-1 -: BIN_W], mags[1][CH_W-1 -: BIN_W],
                  mags[2][CH_W-1 -: BIN_W]};
    endfunction

endpackage
`default_nettype wire

/* sv/smh_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smh_lane
// one channel: sobel sums or raw pixel, squares, bit-per-cycle square root
// ----------------------------------------------------------------------------
module smh_lane (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic              use_raw,
    input  wire smh_pkg::lane_pix_t pix,
    output logic                   done,
    output logic [7:0]             mag
);
    import smh_pkg::*;

    typedef enum logic [2:0] {
        LN_IDLE = 3'b001,
        LN_SQ   = 3'b010,
        LN_ROOT = 3'b100
    } ln_state_t;

    ln_state_t         state_reg, state_next;
    logic signed [8:0] gx_reg, gy_reg, gx_next, gy_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic [7:0]        root_reg, root_next, bit_reg, bit_next;
    logic              done_reg, done_next;

    logic signed [10:0] p [TAPS];
    logic signed [10:0] sx, sy, sx_adj, sy_adj, sx_div, sy_div;
    logic signed [17:0] gx_sq, gy_sq;
    logic [7:0]         trial;
    logic [15:0]        trial_sq;

    always_comb begin
        for (int i = 0; i < TAPS; i++) begin
            p[i] = signed'({3'b000, pix[i]});
        end
        sx = p[2] - p[0] + 11'sd2 * (p[5] - p[3]) + p[8] - p[6];
        sy = p[0] + 11'sd2 * p[1] + p[2] - p[6] - 11'sd2 * p[7] - p[8];
        // truncate toward zero
        sx_adj = sx[10] ? sx + 11'sd3 : sx;
        sy_adj = sy[10] ? sy + 11'sd3 : sy;
        sx_div = sx_adj >>> 2;
        sy_div = sy_adj >>> 2;
        if (use_raw) begin
            gx_next = signed'({1'b0, pix[TAPS-1]});
            gy_next = signed'({1'b0, pix[TAPS-1]});
        end else begin
            gx_next = sx_div[8:0];
            gy_next = sy_div[8:0];
        end
    end

    assign gx_sq    = gx_reg * gx_reg;
    assign gy_sq    = gy_reg * gy_reg;
    assign trial    = root_reg | bit_reg;
    assign trial_sq = trial * trial;

    always_comb begin
        state_next = state_reg;
        sq_next    = sq_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            LN_IDLE: begin
                if (start) begin
                    state_next = LN_SQ;
                end
            end
            LN_SQ: begin
                sq_next    = $unsigned(gx_sq) + $unsigned(gy_sq);
                root_next  = 8'd0;
                bit_next   = 8'h80;
                state_next = LN_ROOT;
            end
            LN_ROOT: begin
                if ({2'b00, trial_sq} <= sq_reg) begin
                    root_next = trial;
                end
                bit_next = bit_reg >> 1;
                if (bit_reg[0]) begin
                    done_next  = 1'b1;
                    state_next = LN_IDLE;
                end
            end
            default: state_next = LN_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LN_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == LN_IDLE && start) begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
        end
        sq_reg   <= sq_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign done = done_reg;
    assign mag  = root_reg;

endmodule
`default_nettype wire

/* sv/smh_hist.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smh_hist
// 512-bin count memory: clear, read, saturating increment
// ----------------------------------------------------------------------------
module smh_hist (
    input  wire logic                  aclk,
    input  wire smh_pkg::hist_cmd_t    cmd,
    output logic [smh_pkg::CNT_W-1:0]  rd_data
);
    import smh_pkg::*;

    logic [CNT_W-1:0] mem [HIST_DEPTH];
    logic [CNT_W-1:0] rd_data_reg;

    // increment uses the word read in the cycle before
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            HOP_NONE:  ;
            HOP_CLEAR: mem[cmd.addr] <= '0;
            HOP_READ:  rd_data_reg <= mem[cmd.addr];
            HOP_INC: begin
                if (rd_data_reg != COUNT_MAX) begin
                    mem[cmd.addr] <= rd_data_reg + CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* sv/sobel_magnitude_histogram_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_magnitude_histogram_top
// 3x3 sobel gradient magnitude colour histogram over a raster pixel stream
// ----------------------------------------------------------------------------
//  channel   handshake            word
//  s_        s_valid / s_ready    mode, chan0..2, bin_index
//  m_        m_valid / m_ready    bin_count, frame_complete
//  cfg_      cfg_wr_en only       cfg_index, cfg_wr_data (12 bits)
//
//  a pixel word runs in order: accept, line store read, window update, then
//  for each of its counts (none, one or two): start, lane work of gradient
//  capture, square sum and an eight-step root, then read and write of a bin
//  a read word is registered in the histogram, then in the output register;
//  a result waiting in the output register holds back only a following read word
//  reset and start frame run a clearing pass over all 512 histogram bins
//  during which no word is accepted; configuration writes are always taken
// ----------------------------------------------------------------------------
module sobel_magnitude_histogram_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_index,
    input  wire logic [smh_pkg::CFG_W-1:0]     cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_mode,
    input  wire logic [7:0]                    s_chan0,
    input  wire logic [7:0]                    s_chan1,
    input  wire logic [7:0]                    s_chan2,
    input  wire logic [smh_pkg::HIST_AW-1:0]   s_bin_index,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [smh_pkg::CNT_W-1:0]          m_bin_count,
    output logic                               m_frame_complete
);
    import smh_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WC_W  = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int HC_W  = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b0000000001,
        ST_IDLE   = 10'b0000000010,
        ST_PX_RD  = 10'b0000000100,
        ST_PX_WIN = 10'b0000001000,
        ST_GO     = 10'b0000010000,
        ST_LANE   = 10'b0000100000,
        ST_HRD    = 10'b0001000000,
        ST_HINC   = 10'b0010000000,
        ST_RD_OUT = 10'b0100000000,
        ST_SPARE  = 10'b1000000000
    } st_t;

    st_t state_reg, state_next;

    // configuration
    logic [CFG_W-1:0] width_cfg_reg, height_cfg_reg;

    // frame position and window
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic             frame_done_reg;
    logic [PIX_W-1:0] win_reg [3][2];
    logic [PIX_W-1:0] snap_reg [3][3];
    logic [PIX_W-1:0] px_reg;
    logic [HIST_AW-1:0] bin_req_reg;
    logic             raw_sel_reg, pend_inter_reg;
    logic [HIST_AW-1:0] clr_cnt_reg;

    // line stores
    logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0] lower_mem [MAX_WIDTH];
    logic [PIX_W-1:0] up_rd_reg, lo_rd_reg;

    // output register
    logic             m_valid_reg;
    logic [CNT_W-1:0] bin_count_reg;
    logic             frame_complete_reg;

    logic             s_fire;
    logic [WC_W-1:0]  w_eff, w_m1, w_ext;
    logic [HC_W-1:0]  h_eff, h_m1, h_ext;
    logic             last_col, last_row, border_need, inter_need;
    logic [PIX_W-1:0] s_px;

    lane_pix_t        lane_pix [NUM_LANES];
    logic [NUM_LANES-1:0] lane_done;
    mag_set_t         lane_mag;
    logic             lane_start;
    hist_cmd_t        hist_cmd;
    logic [CNT_W-1:0] hist_rd;

    assign s_px   = {s_chan2, s_chan1, s_chan0};
    assign s_fire = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE) && !(m_valid_reg && s_mode == MODE_READ);

    // effective frame size, zero acts as one and oversize as the maximum
    always_comb begin
        w_ext = WC_W'(width_cfg_reg);
        h_ext = HC_W'(height_cfg_reg);
        if (w_ext == '0) begin
            w_eff = WC_W'(1);
        end else if (w_ext > WC_W'(MAX_WIDTH)) begin
            w_eff = WC_W'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (h_ext == '0) begin
            h_eff = HC_W'(1);
        end else if (h_ext > HC_W'(MAX_HEIGHT)) begin
            h_eff = HC_W'(MAX_HEIGHT);
        end else begin
            h_eff = h_ext;
        end
        w_m1        = w_eff - WC_W'(1);
        h_m1        = h_eff - HC_W'(1);
        last_col    = WC_W'(col_reg) >= w_m1;
        last_row    = HC_W'(row_reg) >= h_m1;
        border_need = (row_reg == '0) || (col_reg == '0) || last_col || last_row;
        inter_need  = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
    end

    // lanes, one per colour channel
    always_comb begin
        for (int ch = 0; ch < NUM_LANES; ch++) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    lane_pix[ch][r*3+c] = snap_reg[r][c][ch*CH_W +: CH_W];
                end
            end
        end
    end

    assign lane_start = (state_reg == ST_GO);

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        smh_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (lane_start),
            .use_raw (raw_sel_reg),
            .pix     (lane_pix[g]),
            .done    (lane_done[g]),
            .mag     (lane_mag[g])
        );
    end

    // histogram commands
    always_comb begin
        hist_cmd.op   = HOP_NONE;
        hist_cmd.addr = bin_req_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                hist_cmd.op   = HOP_CLEAR;
                hist_cmd.addr = clr_cnt_reg;
            end
            ST_IDLE: begin
                if (s_fire && s_mode == MODE_READ) begin
                    hist_cmd.op   = HOP_READ;
                    hist_cmd.addr = s_bin_index;
                end
            end
            ST_HRD: begin
                hist_cmd.op   = HOP_READ;
                hist_cmd.addr = bin_of(lane_mag);
            end
            ST_HINC: begin
                hist_cmd.op   = HOP_INC;
                hist_cmd.addr = bin_req_reg;
            end
            default: ;
        endcase
    end

    smh_hist u_hist (
        .aclk    (aclk),
        .cmd     (hist_cmd),
        .rd_data (hist_rd)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == HIST_AW'(HIST_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_mode)
                        MODE_PIXEL: state_next = frame_done_reg ? ST_IDLE : ST_PX_RD;
                        MODE_READ:  state_next = ST_RD_OUT;
                        MODE_START: state_next = ST_CLEAR;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PX_RD:  state_next = ST_PX_WIN;
            ST_PX_WIN: state_next = (border_need || inter_need) ? ST_GO : ST_IDLE;
            ST_GO:     state_next = ST_LANE;
            ST_LANE:   state_next = (&lane_done) ? ST_HRD : ST_LANE;
            ST_HRD:    state_next = ST_HINC;
            ST_HINC:   state_next = pend_inter_reg ? ST_GO : ST_IDLE;
            ST_RD_OUT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            frame_done_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            width_cfg_reg  <= FRAME_WIDTH_RST;
            height_cfg_reg <= FRAME_HEIGHT_RST;
            pend_inter_reg <= 1'b0;
            raw_sel_reg    <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= '0;
                win_reg[r][1] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  width_cfg_reg  <= cfg_wr_data;
                    REG_FRAME_HEIGHT: height_cfg_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: clr_cnt_reg <= clr_cnt_reg + HIST_AW'(1);
                ST_IDLE: begin
                    if (s_fire && s_mode == MODE_START) begin
                        clr_cnt_reg    <= '0;
                        col_reg        <= '0;
                        row_reg        <= '0;
                        frame_done_reg <= 1'b0;
                        for (int r = 0; r < 3; r++) begin
                            win_reg[r][0] <= '0;
                            win_reg[r][1] <= '0;
                        end
                    end
                end
                ST_PX_WIN: begin
                    // shift the window one column left
                    for (int r = 0; r < 3; r++) begin
                        win_reg[r][0] <= win_reg[r][1];
                    end
                    win_reg[0][1]  <= up_rd_reg;
                    win_reg[1][1]  <= lo_rd_reg;
                    win_reg[2][1]  <= px_reg;
                    raw_sel_reg    <= border_need;
                    pend_inter_reg <= border_need && inter_need;
                    if (last_col) begin
                        col_reg <= '0;
                        if (last_row) begin
                            frame_done_reg <= 1'b1;
                        end else begin
                            row_reg <= row_reg + ROW_W'(1);
                        end
                    end else begin
                        col_reg <= col_reg + COL_W'(1);
                    end
                end
                ST_HINC: begin
                    raw_sel_reg    <= 1'b0;
                    pend_inter_reg <= 1'b0;
                end
                ST_RD_OUT: m_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            px_reg <= s_px;
        end
        if (state_reg == ST_PX_WIN) begin
            for (int r = 0; r < 3; r++) begin
                snap_reg[r][0] <= win_reg[r][0];
                snap_reg[r][1] <= win_reg[r][1];
            end
            snap_reg[0][2] <= up_rd_reg;
            snap_reg[1][2] <= lo_rd_reg;
            snap_reg[2][2] <= px_reg;
        end
        if (state_reg == ST_HRD) begin
            bin_req_reg <= bin_of(lane_mag);
        end
        if (state_reg == ST_RD_OUT) begin
            bin_count_reg      <= hist_rd;
            frame_complete_reg <= frame_done_reg;
        end
    end

    // line store of the row two above
    always_ff @(posedge aclk) begin
        if (state_reg == ST_PX_RD) begin
            up_rd_reg <= upper_mem[col_reg];
        end
        if (state_reg == ST_PX_WIN) begin
            upper_mem[col_reg] <= lo_rd_reg;
        end
    end

    // line store of the row above
    always_ff @(posedge aclk) begin
        if (state_reg == ST_PX_RD) begin
            lo_rd_reg <= lower_mem[col_reg];
        end
        if (state_reg == ST_PX_WIN) begin
            lower_mem[col_reg] <= px_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_bin_count      = bin_count_reg;
    assign m_frame_complete = frame_complete_reg;

endmodule
`default_nettype wire
